@@ sv/lus_pkg.sv @@
// Package for the LU linear system solver: command codes, sequencer states,
// fixed-point constants and helpers. No dependencies.
package lus_pkg;

  localparam int unsigned ORDER_DEF     = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned ACC_W         = 64;

  typedef enum logic [1:0] {
    CMD_WR_MAT = 2'd0,
    CMD_WR_RHS = 2'd1,
    CMD_SOLVE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DIFF,
    ST_DIV,
    ST_DIVWAIT,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_U,
    PH_L,
    PH_FWD,
    PH_BACK
  } phase_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
    logic zero;
  } div_ctl_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] qmax;
    logic signed [ACC_W+1:0] qmin;
    qmax = (ACC_W+2)'(32'sh7fffffff);
    qmin = -(ACC_W+2)'(64'sh80000000);
    if (v > qmax) begin
      sat_q = 32'sh7fffffff;
    end else if (v < qmin) begin
      sat_q = 32'sh80000000;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

  function automatic logic sat_hit(input logic signed [ACC_W+1:0] v);
    sat_hit = (v > (ACC_W+2)'(32'sh7fffffff)) || (v < -(ACC_W+2)'(64'sh80000000));
  endfunction

endpackage

@@ sv/lu_linear_system_solver.sv @@
// Top level of the LU linear system solver: load store, sequencer, shared
// multiplier and accumulator. Depends on lus_pkg and lus_divider.
//
// Load requests (matrix and right-hand-side writes) go straight into the
// load store. A solve request factors the matrix (Doolittle, no pivoting), runs
// forward and back substitution and emits ORDER results, the last one marked.
// During a solve the input is stalled. The time is set by one shared 32x32
// multiplier used once per multiply-accumulate term (read, multiply, accumulate;
// ORDER*(ORDER-1)*(2*ORDER+5)/6 terms), by a read, difference and store per
// target entry, and by one bit-serial divider (ORDER*(ORDER+1)/2 quotients).
// Each result is then read out and held while the output stalls. Singular and
// overflow are run-wide flags.
module lu_linear_system_solver #(
  parameter int unsigned ORDER     = lus_pkg::ORDER_DEF,
  parameter int unsigned FRAC_BITS = lus_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_index,
  output logic signed [31:0] out_solution,
  output logic        out_singular,
  output logic        out_overflow,
  output logic        out_last
);
  import lus_pkg::*;

  localparam int unsigned IW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int unsigned AW = $clog2(ORDER * ORDER);
  localparam int unsigned VW = $clog2(ORDER + 1);

  logic signed [Q_W-1:0] mat_mem [ORDER*ORDER];
  logic signed [Q_W-1:0] fac_mem [ORDER*ORDER];
  logic signed [Q_W-1:0] vec_mem [3*ORDER];

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [IW-1:0] m_r, m_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [VW-1:0] kc_r, kc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [Q_W-1:0] opa_r, opb_r, ent_r, piv_r, diff_r, diff_nxt;
  logic signed [2*Q_W-1:0] prod_r;
  logic ovf_r, ovf_nxt, sing_r, sing_nxt;
  logic [IW-1:0] oi_r, oi_nxt;
  logic ov_r, ov_nxt;
  logic signed [Q_W-1:0] osol_r;
  logic div_start;
  div_ctl_t div_ctl;
  logic signed [ACC_W+1:0] quot;
  logic signed [ACC_W+1:0] dwide;
  logic signed [ACC_W-1:0] prod_rnd;
  logic do_load;
  logic wr_fac, wr_vec;
  logic [AW-1:0] fac_wa;
  logic [$clog2(3*ORDER)-1:0] vec_wa;
  logic signed [Q_W-1:0] wr_data;
  logic [IW-1:0] last_idx;

  assign last_idx = IW'(ORDER - 1);

  function automatic logic [AW-1:0] fa(input logic [IW-1:0] r, input logic [IW-1:0] c);
    fa = AW'(r * ORDER + c);
  endfunction

  function automatic logic [$clog2(3*ORDER)-1:0] va(input int unsigned b,
                                                     input logic [IW-1:0] i);
    va = ($clog2(3*ORDER))'(b * ORDER + i);
  endfunction

  assign in_stall = (st_r != ST_IDLE);
  assign do_load  = in_valid && !in_stall;

  // operand rows/columns for the current term k
  logic [IW-1:0] ar, ac, br, bc, er, ec;
  always_comb begin
    ar = m_r; ac = k_r; br = k_r; bc = j_r; er = m_r; ec = j_r;
    case (ph_r)
      PH_U:    begin ar = m_r; ac = k_r; br = k_r; bc = j_r; er = m_r; ec = j_r; end
      PH_L:    begin ar = j_r; ac = k_r; br = k_r; bc = m_r; er = j_r; ec = m_r; end
      PH_FWD:  begin ar = m_r; ac = k_r; br = k_r; er = m_r; end
      PH_BACK: begin ar = m_r; ac = k_r; br = k_r; er = m_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_load && in_cmd == CMD_WR_MAT && in_row < ORDER && in_col < ORDER) begin
      mat_mem[fa(IW'(in_row), IW'(in_col))] <= in_value;
    end
    if (do_load && in_cmd == CMD_WR_RHS && in_row < ORDER) begin
      vec_mem[va(0, IW'(in_row))] <= in_value;
    end else if (wr_vec) begin
      vec_mem[vec_wa] <= wr_data;
    end
    if (wr_fac) begin
      fac_mem[fac_wa] <= wr_data;
    end
    if (st_r == ST_RD) begin
      opa_r <= fac_mem[fa(ar, ac)];
      if (ph_r == PH_FWD) begin
        opb_r <= vec_mem[va(1, br)];
        ent_r <= vec_mem[va(0, er)];
      end else if (ph_r == PH_BACK) begin
        opb_r <= vec_mem[va(2, br)];
        ent_r <= vec_mem[va(1, er)];
      end else begin
        opb_r <= fac_mem[fa(br, bc)];
        ent_r <= mat_mem[fa(er, ec)];
      end
      piv_r <= fac_mem[fa(m_r, m_r)];
    end
    if (st_r == ST_MUL) begin
      prod_r <= opa_r * opb_r;
    end
    if (st_r == ST_EMIT && !ov_r) begin
      osol_r <= vec_mem[va(2, oi_r)];
    end
  end

  assign prod_rnd = (prod_r + (ACC_W)'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign dwide = $signed({{2{ent_r[Q_W-1]}}, {(ACC_W-Q_W){ent_r[Q_W-1]}}, ent_r})
               - $signed({{2{acc_r[ACC_W-1]}}, acc_r});

  // term count for current target: U/L/FWD use k<m,
  // BACK uses k from ORDER-1 down to m+1
  logic [VW-1:0] nterm;
  always_comb begin
    case (ph_r)
      PH_U, PH_L, PH_FWD: nterm = VW'(m_r);
      PH_BACK:            nterm = VW'(ORDER - 1 - m_r);
      default:            nterm = '0;
    endcase
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; m_nxt = m_r; j_nxt = j_r; k_nxt = k_r;
    kc_nxt = kc_r; acc_nxt = acc_r; diff_nxt = diff_r;
    ovf_nxt = ovf_r; sing_nxt = sing_r; oi_nxt = oi_r; ov_nxt = ov_r;
    case (st_r)
      ST_IDLE: begin
        if (do_load && in_cmd == CMD_SOLVE) begin
          st_nxt = ST_RD; ph_nxt = PH_U; m_nxt = '0; j_nxt = '0;
          k_nxt = '0; kc_nxt = '0; acc_nxt = '0; ovf_nxt = 1'b0; sing_nxt = 1'b0;
        end
      end
      ST_RD:  st_nxt = (kc_r < nterm) ? ST_MUL : ST_DIFF;
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = acc_r + prod_rnd;
        kc_nxt = kc_r + 1'b1;
        k_nxt = (ph_r == PH_BACK) ? k_r - 1'b1 : k_r + 1'b1;
        st_nxt = ST_RD;
      end
      ST_DIFF: begin
        diff_nxt = sat_q(dwide);
        if (sat_hit(dwide)) ovf_nxt = 1'b1;
        st_nxt = (ph_r == PH_L || ph_r == PH_BACK) ? ST_DIV : ST_STORE;
      end
      ST_DIV: st_nxt = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_ctl.done) begin
          if (div_ctl.zero) sing_nxt = 1'b1;
          else if (sat_hit(quot)) ovf_nxt = 1'b1;
          st_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        acc_nxt = '0; kc_nxt = '0; st_nxt = ST_RD;
        case (ph_r)
          PH_U: begin
            k_nxt = '0;
            if (j_r == last_idx) begin
              if (m_r == last_idx) begin
                ph_nxt = PH_FWD; m_nxt = '0;
              end else begin
                ph_nxt = PH_L; j_nxt = m_r + 1'b1;
              end
            end else j_nxt = j_r + 1'b1;
          end
          PH_L: begin
            k_nxt = '0;
            if (j_r == last_idx) begin
              ph_nxt = PH_U; m_nxt = m_r + 1'b1; j_nxt = m_r + 1'b1;
            end else j_nxt = j_r + 1'b1;
          end
          PH_FWD: begin
            k_nxt = '0;
            if (m_r == last_idx) begin
              ph_nxt = PH_BACK; m_nxt = last_idx; k_nxt = last_idx;
            end else m_nxt = m_r + 1'b1;
          end
          PH_BACK: begin
            k_nxt = last_idx;
            if (m_r == '0) begin
              st_nxt = ST_EMIT; oi_nxt = '0; ov_nxt = 1'b0;
            end else m_nxt = m_r - 1'b1;
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
        end else if (!out_stall) begin
          ov_nxt = 1'b0;
          if (oi_r == last_idx) st_nxt = ST_IDLE;
          else oi_nxt = oi_r + 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = (st_r == ST_DIV);
    wr_fac = 1'b0; wr_vec = 1'b0;
    fac_wa = fa(m_r, j_r); vec_wa = va(1, m_r);
    wr_data = diff_r;
    if (st_r == ST_STORE) begin
      case (ph_r)
        PH_U:    begin wr_fac = 1'b1; fac_wa = fa(m_r, j_r); wr_data = diff_r; end
        PH_L:    begin wr_fac = 1'b1; fac_wa = fa(j_r, m_r); wr_data = sat_q(quot); end
        PH_FWD:  begin wr_vec = 1'b1; vec_wa = va(1, m_r); wr_data = diff_r; end
        PH_BACK: begin wr_vec = 1'b1; vec_wa = va(2, m_r); wr_data = sat_q(quot); end
        default: ;
      endcase
    end
  end

  lus_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (diff_r),
    .den   (piv_r),
    .ctl   (div_ctl),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_U; ov_r <= 1'b0;
      m_r <= '0; j_r <= '0; k_r <= '0; kc_r <= '0; oi_r <= '0;
      ovf_r <= 1'b0; sing_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ov_r <= ov_nxt;
      m_r <= m_nxt; j_r <= j_nxt; k_r <= k_nxt; kc_r <= kc_nxt; oi_r <= oi_nxt;
      ovf_r <= ovf_nxt; sing_r <= sing_nxt;
    end
    acc_r <= acc_nxt;
    diff_r <= diff_nxt;
  end

  assign out_valid    = ov_r;
  assign out_index    = 3'(oi_r);
  assign out_solution = osol_r;
  assign out_singular = sing_r;
  assign out_overflow = ovf_r;
  assign out_last     = (oi_r == last_idx);

`ifndef SYNTH
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == ST_EMIT)) else $error("result outside emit");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("input open while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (st_r == ST_IDLE))
    else $error("run did not end after last");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (st_r == ST_DIVWAIT)) else $error("divider start lost");
`endif

endmodule

@@ sv/lus_divider.sv @@
// Restoring divider, one quotient bit per cycle, signed truncating quotient.
// Depends on lus_pkg.
module lus_divider #(
  parameter int unsigned FRAC_BITS = lus_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [lus_pkg::Q_W-1:0] num,
  input  logic signed [lus_pkg::Q_W-1:0] den,
  output lus_pkg::div_ctl_t             ctl,
  output logic signed [lus_pkg::ACC_W+1:0] quot
);
  import lus_pkg::*;

  localparam int unsigned NW  = Q_W + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic [NW-1:0]   dvd_r, dvd_nxt;
  logic [Q_W:0]    rem_r, rem_nxt;
  logic [Q_W-1:0]  dsr_r, dsr_nxt;
  logic            neg_r, neg_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [Q_W:0]    trial;
  logic [Q_W:0]    shifted;
  logic [Q_W-1:0]  anum;

  always_comb begin
    anum    = num[Q_W-1] ? (Q_W)'(-num) : num;
    shifted = {rem_r[Q_W-1:0], dvd_r[NW-1]};
    trial   = shifted - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      dvd_nxt  = {anum, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = den[Q_W-1] ? (Q_W)'(-den) : den;
      neg_nxt  = num[Q_W-1] ^ den[Q_W-1];
      busy_nxt = (den != '0);
      done_nxt = (den == '0);
      cnt_nxt  = CW'(NW);
    end else if (busy_r) begin
      if (!trial[Q_W]) begin
        rem_nxt = trial;
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    ctl.start = start;
    ctl.busy  = busy_r;
    ctl.done  = done_r;
    ctl.zero  = (dsr_r == '0);
    if (dsr_r == '0) begin
      quot = '0;
    end else if (neg_r) begin
      quot = -$signed({{(ACC_W+2-NW){1'b0}}, dvd_r});
    end else begin
      quot = $signed({{(ACC_W+2-NW){1'b0}}, dvd_r});
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1) && !start) |=> (done_r && !busy_r))
    else $error("divider did not finish");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
`endif

endmodule
